// ===== hw/rtl/qbst_pkg.sv =====
// Shared types and constants of the quadratic Bezier strip tessellator.
`timescale 1ns / 1ps
package qbst_pkg;

    localparam int IDX_W  = 6;   // sample index width, covers any segment count in range
    localparam int LEN2_W = 33;  // squared chord length
    localparam int ROOT_W = 29;  // chord length in Q.12
    localparam int QB     = 10;  // quotient bits of the offset divider

    // Per-sample control bits that travel with the data.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             start;
    } t_meta;

    // One sample request: curve points and the curve parameter t (Q1.16).
    typedef struct packed {
        t_meta              meta;
        logic [16:0]        t;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } t_smp;

    // Sample point and chord data carried through the length and divide units.
    typedef struct packed {
        t_meta              meta;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic               neg_x;  // x offset is negative (dy < 0)
        logic               neg_y;  // y offset is negative (dx > 0)
        logic [15:0]        adx;    // |dx|
        logic [15:0]        ady;    // |dy|
    } t_pt;

endpackage

// ===== hw/rtl/qbst_seq.sv =====
// Curve holder and sample sequencer: issues one sample request per cycle while enabled.
`timescale 1ns / 1ps
module qbst_seq #(
    parameter int SEGMENTS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic [95:0]       i_tdata,
    output logic              o_vld,
    output qbst_pkg::t_smp    o_smp
);
    import qbst_pkg::*;

    localparam int IW = $clog2(SEGMENTS + 1);

    logic [16:0]   w_t_tab [SEGMENTS+1];
    logic          r_busy;
    logic [IW-1:0] r_idx;
    logic [95:0]   r_curve;
    logic          r_vld;
    t_smp          r_smp;
    logic          w_end;
    logic          w_take;

    // t = round(i / SEGMENTS) in Q1.16, ties up; worked out at elaboration.
    for (genvar g = 0; g <= SEGMENTS; g++) begin : g_ttab
        assign w_t_tab[g] = 17'((g * 65536 + SEGMENTS / 2) / SEGMENTS);
    end

    assign w_end    = (r_idx == IW'(SEGMENTS));
    assign o_tready = !r_busy || (i_en && w_end);
    assign w_take   = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_en) r_vld <= r_busy;
            if (w_take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (i_en && r_busy) begin
                if (w_end) r_busy <= 1'b0;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_curve <= i_tdata;
        if (i_en) begin
            r_smp.meta.idx   <= IDX_W'(r_idx);
            r_smp.meta.last  <= w_end;
            r_smp.meta.start <= (r_idx == '0);
            r_smp.t          <= w_t_tab[r_idx];
            r_smp.sx         <= $signed(r_curve[15:0]);
            r_smp.sy         <= $signed(r_curve[31:16]);
            r_smp.cx         <= $signed(r_curve[47:32]);
            r_smp.cy         <= $signed(r_curve[63:48]);
            r_smp.ex         <= $signed(r_curve[79:64]);
            r_smp.ey         <= $signed(r_curve[95:80]);
        end
    end

    assign o_vld = r_vld;
    assign o_smp = r_smp;
endmodule

// ===== hw/rtl/qbst_eval.sv =====
// Curve evaluator: two lerp levels, rounding, chord and squared chord length.
`timescale 1ns / 1ps
module qbst_eval (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  qbst_pkg::t_smp               i_smp,
    output logic                         o_vld,
    output qbst_pkg::t_pt                o_pt,
    output logic [qbst_pkg::LEN2_W-1:0]  o_len2
);
    import qbst_pkg::*;

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    t_meta              r1_meta, r2_meta, r3_meta;
    logic [16:0]        r1_t;
    logic signed [33:0] r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [33:0] r2_px, r2_py;
    logic signed [15:0] r3_nx, r3_ny;
    logic signed [15:0] r_prev_x, r_prev_y;
    t_pt                r4_pt;
    logic [LEN2_W-1:0]  r4_len2;

    logic signed [17:0] w_t0, w_t1;
    logic signed [34:0] w_max, w_may, w_mbx, w_mby;
    logic signed [34:0] w_dx2, w_dy2;
    logic signed [52:0] w_mx, w_my;
    logic signed [16:0] w_dx, w_dy;
    logic signed [33:0] w_sqx, w_sqy;
    logic [34:0]        w_sum;

    assign w_t0 = $signed({1'b0, i_smp.t});
    assign w_t1 = $signed({1'b0, r1_t});

    // First level: a = s + (c - s) t and b = c + (e - c) t, exact in Q.16.
    assign w_max = 35'(17'(i_smp.cx) - 17'(i_smp.sx)) * 35'(w_t0);
    assign w_may = 35'(17'(i_smp.cy) - 17'(i_smp.sy)) * 35'(w_t0);
    assign w_mbx = 35'(17'(i_smp.ex) - 17'(i_smp.cx)) * 35'(w_t0);
    assign w_mby = 35'(17'(i_smp.ey) - 17'(i_smp.cy)) * 35'(w_t0);

    // Second level: p = a + floor(((b - a) t + 2^15) / 2^16).
    assign w_dx2 = 35'(r1_bx) - 35'(r1_ax);
    assign w_dy2 = 35'(r1_by) - 35'(r1_ay);
    assign w_mx  = 53'(w_dx2) * 53'(w_t1);
    assign w_my  = 53'(w_dy2) * 53'(w_t1);

    // Chord from the previous sample of the same curve.
    assign w_dx  = 17'(r3_nx) - 17'(r_prev_x);
    assign w_dy  = 17'(r3_ny) - 17'(r_prev_y);
    assign w_sqx = 34'(w_dx) * 34'(w_dx);
    assign w_sqy = 34'(w_dy) * 34'(w_dy);
    assign w_sum = 35'(unsigned'(w_sqx)) + 35'(unsigned'(w_sqy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_meta <= i_smp.meta;
            r1_t    <= i_smp.t;
            r1_ax   <= (34'(i_smp.sx) <<< 16) + 34'(w_max);
            r1_ay   <= (34'(i_smp.sy) <<< 16) + 34'(w_may);
            r1_bx   <= (34'(i_smp.cx) <<< 16) + 34'(w_mbx);
            r1_by   <= (34'(i_smp.cy) <<< 16) + 34'(w_mby);

            r2_meta <= r1_meta;
            r2_px   <= r1_ax + 34'((w_mx + 53'sd32768) >>> 16);
            r2_py   <= r1_ay + 34'((w_my + 53'sd32768) >>> 16);

            r3_meta <= r2_meta;
            r3_nx   <= 16'((35'(r2_px) + 35'sd32768) >>> 16);
            r3_ny   <= 16'((35'(r2_py) + 35'sd32768) >>> 16);

            if (r3_vld) begin
                r_prev_x <= r3_nx;
                r_prev_y <= r3_ny;
            end
            r4_pt.meta  <= r3_meta;
            r4_pt.nx    <= r3_nx;
            r4_pt.ny    <= r3_ny;
            r4_pt.neg_x <= w_dy < 0;
            r4_pt.neg_y <= w_dx > 0;
            r4_pt.adx   <= 16'((w_dx < 0) ? -w_dx : w_dx);
            r4_pt.ady   <= 16'((w_dy < 0) ? -w_dy : w_dy);
            // The start sample has no chord; a zero length yields no offset.
            r4_len2     <= r3_meta.start ? '0 : w_sum[LEN2_W-1:0];
        end
    end

    assign o_vld  = r4_vld;
    assign o_pt   = r4_pt;
    assign o_len2 = r4_len2;
endmodule

// ===== hw/rtl/qbst_isqrt.sv =====
// Pipelined integer square root of len2 * 2^24, one root bit per stage.
`timescale 1ns / 1ps
module qbst_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  qbst_pkg::t_pt                i_pt,
    input  logic [qbst_pkg::LEN2_W-1:0]  i_len2,
    output logic                         o_vld,
    output qbst_pkg::t_pt                o_pt,
    output logic [qbst_pkg::ROOT_W-1:0]  o_root
);
    import qbst_pkg::*;

    localparam int NS = ROOT_W;

    logic              r_vld  [NS];
    t_pt               r_pt   [NS];
    logic [LEN2_W-1:0] r_len2 [NS];
    logic [31:0]       r_rem  [NS];
    logic [ROOT_W-1:0] r_root [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;
        logic              w_vin;
        t_pt               w_pin;
        logic [LEN2_W-1:0] w_lin;
        logic [31:0]       w_rin;
        logic [ROOT_W-1:0] w_qin;
        logic [57:0]       w_v;
        logic [31:0]       w_sh;
        logic [31:0]       w_trial;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_vin = i_vld;
            assign w_pin = i_pt;
            assign w_lin = i_len2;
            assign w_rin = '0;
            assign w_qin = '0;
        end else begin : g_next
            assign w_vin = r_vld[j-1];
            assign w_pin = r_pt[j-1];
            assign w_lin = r_len2[j-1];
            assign w_rin = r_rem[j-1];
            assign w_qin = r_root[j-1];
        end

        assign w_v     = {1'b0, w_lin, 24'b0};
        assign w_sh    = {w_rin[29:0], w_v[2*K+1 -: 2]};
        assign w_trial = {1'b0, w_qin, 2'b01};
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pt[j]   <= w_pin;
                r_len2[j] <= w_lin;
                r_rem[j]  <= w_ge ? (w_sh - w_trial) : w_sh;
                r_root[j] <= {w_qin[ROOT_W-2:0], w_ge};
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_pt   = r_pt[NS-1];
    assign o_root = r_root[NS-1];
endmodule

// ===== hw/rtl/qbst_offdiv.sv =====
// Offset divider: rounded hw*|d|*4096 / L for both axes, one quotient bit per stage.
`timescale 1ns / 1ps
module qbst_offdiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [7:0]                   i_hw,
    input  logic                         i_vld,
    input  qbst_pkg::t_pt                i_pt,
    input  logic [qbst_pkg::ROOT_W-1:0]  i_root,
    output logic                         o_vld,
    output qbst_pkg::t_pt                o_pt,
    output logic                         o_zero,
    output logic [qbst_pkg::QB-1:0]      o_qx,
    output logic [qbst_pkg::QB-1:0]      o_qy
);
    import qbst_pkg::*;

    localparam int NW = 38;
    localparam int DW = ROOT_W + 1;
    localparam int CW = NW + 2;

    logic              r0_vld, r0_zero;
    t_pt               r0_pt;
    logic [NW-1:0]     r0_nx, r0_ny;
    logic [DW-1:0]     r0_d;

    logic              r_vld  [QB];
    t_pt               r_pt   [QB];
    logic              r_zero [QB];
    logic [DW-1:0]     r_d    [QB];
    logic [NW-1:0]     r_nx   [QB];
    logic [NW-1:0]     r_ny   [QB];
    logic [QB-1:0]     r_qx   [QB];
    logic [QB-1:0]     r_qy   [QB];

    // Rounded quotient: (2*mag + L) / (2*L).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_pt   <= i_pt;
            r0_zero <= (i_root == '0);
            r0_nx   <= NW'({24'(i_hw) * 24'(i_pt.ady), 13'b0}) + NW'(i_root);
            r0_ny   <= NW'({24'(i_hw) * 24'(i_pt.adx), 13'b0}) + NW'(i_root);
            r0_d    <= {i_root, 1'b0};
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int K = QB - 1 - j;
        logic          w_vin, w_zin, w_gex, w_gey;
        t_pt           w_pin;
        logic [DW-1:0] w_din;
        logic [NW-1:0] w_xin, w_yin;
        logic [QB-1:0] w_qxin, w_qyin;
        logic [CW-1:0] w_dk;

        if (j == 0) begin : g_first
            assign w_vin  = r0_vld;
            assign w_zin  = r0_zero;
            assign w_pin  = r0_pt;
            assign w_din  = r0_d;
            assign w_xin  = r0_nx;
            assign w_yin  = r0_ny;
            assign w_qxin = '0;
            assign w_qyin = '0;
        end else begin : g_next
            assign w_vin  = r_vld[j-1];
            assign w_zin  = r_zero[j-1];
            assign w_pin  = r_pt[j-1];
            assign w_din  = r_d[j-1];
            assign w_xin  = r_nx[j-1];
            assign w_yin  = r_ny[j-1];
            assign w_qxin = r_qx[j-1];
            assign w_qyin = r_qy[j-1];
        end

        assign w_dk  = CW'(w_din) << K;
        assign w_gex = (CW'(w_xin) >= w_dk);
        assign w_gey = (CW'(w_yin) >= w_dk);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pt[j]   <= w_pin;
                r_zero[j] <= w_zin;
                r_d[j]    <= w_din;
                r_nx[j]   <= w_gex ? NW'(CW'(w_xin) - w_dk) : w_xin;
                r_ny[j]   <= w_gey ? NW'(CW'(w_yin) - w_dk) : w_yin;
                r_qx[j]   <= w_qxin | (QB'(w_gex) << K);
                r_qy[j]   <= w_qyin | (QB'(w_gey) << K);
            end
        end
    end

    assign o_vld  = r_vld[QB-1];
    assign o_pt   = r_pt[QB-1];
    assign o_zero = r_zero[QB-1];
    assign o_qx   = r_qx[QB-1];
    assign o_qy   = r_qy[QB-1];
endmodule

// ===== hw/rtl/quadratic_bezier_strip_tessellator_core.sv =====
// Top level of the quadratic Bezier strip tessellator: sequencer, evaluator, root, divider.
`timescale 1ns / 1ps
// Throughput: one vertex pair per cycle while the output is not stalled, so one curve per
//   SEGMENTS+1 pairs; the sample sequencer issuing one sample per cycle sets that figure.
// Reset: synchronous, active low; clears all valid bits and sets half_width to 24.
// The whole pipeline advances together whenever the output register is free or taken.
module quadratic_bezier_strip_tessellator_core #(
    parameter int SEGMENTS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Curve input: start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (16 bits each, lowest first).
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,
    // Vertex pairs: point_index[4:0], left_x, left_y, right_x, right_y, 3 zero pad bits.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // half_width register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import qbst_pkg::*;

    logic [7:0]        r_hw;
    logic              w_en;

    logic              w_s0_vld;
    t_smp              w_s0;
    logic              w_e_vld;
    t_pt               w_e_pt;
    logic [LEN2_W-1:0] w_e_len2;
    logic              w_r_vld;
    t_pt               w_r_pt;
    logic [ROOT_W-1:0] w_r_root;
    logic              w_d_vld;
    t_pt               w_d_pt;
    logic              w_d_zero;
    logic [QB-1:0]     w_qx, w_qy;

    logic signed [10:0] w_ox, w_oy;
    logic signed [17:0] w_lx, w_ly, w_rx, w_ry;

    logic              r_o_valid;
    logic              r_o_last;
    logic [71:0]       r_o_data;

    // The configuration channel is always ready; the user must write only while idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= 8'd24;
        end else if (i_cfg_valid) begin
            r_hw <= i_cfg_data;
        end
    end

    // Every stage moves when the output register is empty or being drained.
    assign w_en = !r_o_valid || i_m_axis_tready;

    qbst_seq #(.SEGMENTS(SEGMENTS)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .o_vld    (w_s0_vld),
        .o_smp    (w_s0)
    );

    qbst_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s0_vld),
        .i_smp   (w_s0),
        .o_vld   (w_e_vld),
        .o_pt    (w_e_pt),
        .o_len2  (w_e_len2)
    );

    qbst_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_e_vld),
        .i_pt    (w_e_pt),
        .i_len2  (w_e_len2),
        .o_vld   (w_r_vld),
        .o_pt    (w_r_pt),
        .o_root  (w_r_root)
    );

    qbst_offdiv u_offdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_hw    (r_hw),
        .i_vld   (w_r_vld),
        .i_pt    (w_r_pt),
        .i_root  (w_r_root),
        .o_vld   (w_d_vld),
        .o_pt    (w_d_pt),
        .o_zero  (w_d_zero),
        .o_qx    (w_qx),
        .o_qy    (w_qy)
    );

    // Signed offsets; a zero-length chord or the start pair gets none.
    always_comb begin
        w_ox = '0;
        w_oy = '0;
        if (!w_d_zero && !w_d_pt.meta.start) begin
            w_ox = w_d_pt.neg_x ? -11'(w_qx) : 11'(w_qx);
            w_oy = w_d_pt.neg_y ? -11'(w_qy) : 11'(w_qy);
        end
        if (w_d_pt.meta.start) begin
            // The start pair puts its left vertex one pixel up and right of the start.
            w_lx = 18'(w_d_pt.nx) + 18'sd16;
            w_ly = 18'(w_d_pt.ny) + 18'sd16;
        end else begin
            w_lx = 18'(w_d_pt.nx) + 18'(w_ox);
            w_ly = 18'(w_d_pt.ny) + 18'(w_oy);
        end
        w_rx = 18'(w_d_pt.nx) - 18'(w_ox);
        w_ry = 18'(w_d_pt.ny) - 18'(w_oy);
    end

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'h7FFF;
        if (v < -18'sd32768) return 16'h8000;
        return v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_last <= w_d_pt.meta.last;
            r_o_data <= {3'b000, sat16(w_ry), sat16(w_rx), sat16(w_ly), sat16(w_lx),
                         w_d_pt.meta.idx[4:0]};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

    // Start pair check: left x is the start x plus one pixel, saturated.
    logic signed [16:0] w_chk_x;
    assign w_chk_x = 17'($signed(r_o_data[52:37])) + 17'sd16;

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last |-> r_o_data[4:0] == 5'(SEGMENTS))
        else $error("last pair carries a wrong sample index");

    a_start_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_data[4:0] == 5'd0 && !r_o_last |->
        ((w_chk_x > 17'sd32767) ? (r_o_data[20:5] == 16'h7FFF)
                                : (r_o_data[20:5] == w_chk_x[15:0])))
        else $error("start pair left vertex is not offset by one pixel");

    a_curve_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_m_axis_tready && !r_o_last |=> r_o_valid)
        else $error("gap inside the vertex pairs of one curve");
endmodule

// ===== tb/quadratic_bezier_strip_tessellator_core_tb.sv =====
// Self-checking testbench for the quadratic Bezier strip tessellator core.
`timescale 1ns / 1ps
module quadratic_bezier_strip_tessellator_core_tb;

    localparam int SEGS    = 20;
    localparam int LATENCY = 47;

    // One expected vertex pair.
    typedef struct {
        logic [4:0]         point_index;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic               last;
    } t_vertex_pair;

    // Holds the predicted strip vertices and checks the block's output against them.
    class strip_scoreboard;
        t_vertex_pair pending_pairs[$];
        int unsigned  half_width;
        int           mismatches;

        function new();
            half_width = 24;
            mismatches = 0;
        endfunction

        static function longint floor_shr16(longint v);
            return v >>> 16;
        endfunction

        static function longint lerp_q20(longint a, longint b, longint t);
            return a + floor_shr16((b - a) * t + 32768);
        endfunction

        static function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        static function longint int_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // Rounds to nearest with ties away from zero.
        static function longint div_round(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag * 2 + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function void push_pair(int idx, longint lx, longint ly, longint rx, longint ry);
            t_vertex_pair p;
            p.point_index = idx[4:0];
            p.left_x = 16'(clamp16(lx));
            p.left_y = 16'(clamp16(ly));
            p.right_x = 16'(clamp16(rx));
            p.right_y = 16'(clamp16(ry));
            p.last = (idx == SEGS);
            pending_pairs.push_back(p);
        endfunction

        // Expands an accepted curve into its SEGS+1 vertex pairs.
        function void note_curve(logic [95:0] curve);
            longint sx, sy, cx, cy, ex, ey, px, py, t;
            longint ax, ay, bx, by, nx, ny, dx, dy, ox, oy, len12;
            longint unsigned len2;
            sx = $signed(curve[15:0]);
            sy = $signed(curve[31:16]);
            cx = $signed(curve[47:32]);
            cy = $signed(curve[63:48]);
            ex = $signed(curve[79:64]);
            ey = $signed(curve[95:80]);
            push_pair(0, sx + 16, sy + 16, sx, sy);
            px = sx;
            py = sy;
            for (int i = 1; i <= SEGS; i++) begin
                t = (i * 65536 + SEGS / 2) / SEGS;
                ax = lerp_q20(sx * 65536, cx * 65536, t);
                ay = lerp_q20(sy * 65536, cy * 65536, t);
                bx = lerp_q20(cx * 65536, ex * 65536, t);
                by = lerp_q20(cy * 65536, ey * 65536, t);
                nx = floor_shr16(lerp_q20(ax, bx, t) + 32768);
                ny = floor_shr16(lerp_q20(ay, by, t) + 32768);
                dx = nx - px;
                dy = ny - py;
                len2 = dx * dx + dy * dy;
                ox = 0;
                oy = 0;
                if (len2 != 0) begin
                    len12 = int_sqrt(len2 << 24);
                    ox = div_round(longint'(half_width) * dy * 4096, len12);
                    oy = div_round(-longint'(half_width) * dx * 4096, len12);
                end
                push_pair(i, nx + ox, ny + oy, nx - ox, ny - oy);
                px = nx;
                py = ny;
            end
        endfunction

        function void check_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_pair(logic [71:0] data, logic tlast);
            t_vertex_pair e;
            if (pending_pairs.size() == 0) begin
                $error("vertex pair: unexpected transfer, data %h", data);
                mismatches++;
                return;
            end
            e = pending_pairs.pop_front();
            check_field("point_index", e.point_index, data[4:0]);
            check_field("left_x", e.left_x, $signed(data[20:5]));
            check_field("left_y", e.left_y, $signed(data[36:21]));
            check_field("right_x", e.right_x, $signed(data[52:37]));
            check_field("right_y", e.right_y, $signed(data[68:53]));
            check_field("last", e.last, tlast);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [71:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    strip_scoreboard scoreboard = new();
    int send_idle_pct;
    int recv_stall_pct;

    quadratic_bezier_strip_tessellator_core #(.SEGMENTS(SEGS)) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tlast(o_m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The receiver stalls at random and checks every output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            scoreboard.check_pair(o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sends one curve, with a random idle gap ahead of it. Valid stays high after
    // the transfer until the next idle gap or the next drain.
    task automatic send_curve(logic [95:0] curve);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= curve;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        scoreboard.note_curve(curve);
        @(negedge i_clk);
    endtask

    task automatic send_points(int sx, int sy, int cx, int cy, int ex, int ey);
        send_curve({ey[15:0], ex[15:0], cy[15:0], cx[15:0], sy[15:0], sx[15:0]});
    endtask

    // Writes half_width; called only with the pipeline drained.
    task automatic write_half_width(logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        scoreboard.half_width = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (scoreboard.pending_pairs.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    // Mostly small curves so offsets and chords vary; some span the full range.
    function automatic logic [95:0] random_curve();
        logic [95:0] c;
        int base_x, base_y, spread;
        c = {$urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            spread = 1 << $urandom_range(2, 11);
            base_x = $urandom_range(0, 65535) - 32768;
            base_y = $urandom_range(0, 65535) - 32768;
            for (int k = 0; k < 3; k++) begin
                c[32*k +: 16] = 16'(base_x + $urandom_range(0, spread) - spread / 2);
                c[32*k+16 +: 16] = 16'(base_y + $urandom_range(0, spread) - spread / 2);
            end
        end
        return c;
    endfunction

    task automatic random_curves(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_curve(random_curve());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed curves at reset width: extremes, degenerate and straight lines.
        send_points(0, 0, 0, 0, 0, 0);
        send_points(32767, 32767, 32767, 32767, 32767, 32767);
        send_points(-32768, -32768, -32768, -32768, -32768, -32768);
        send_points(-32768, -32768, 32767, 32767, -32768, 32767);
        send_points(32767, -32768, -32768, 32767, 32767, 32767);
        send_points(0, 0, 160, 0, 320, 0);
        send_points(0, 0, 0, -160, 0, -320);
        send_points(100, 100, 500, -300, 100, 100);
        send_points(-32768, 32767, 0, 0, 32767, -32768);
        send_points(5, 5, 6, 5, 7, 6);
        drain();

        write_half_width(8'd255);
        send_points(32767, 0, 32767, 1000, 32767, 2000);
        send_points(-32768, 0, -32768, -1000, -32768, -2000);
        send_points(0, 32767, 1000, 32767, 2000, 32767);
        send_points(0, -32768, -1000, -32768, -2000, -32768);
        send_points(-300, 40, 900, 1200, 3, -77);
        drain();

        write_half_width(8'd0);
        send_points(-1000, 2000, 3000, -4000, 500, 600);
        send_points(1, 2, 3, 4, 5, 6);
        drain();

        write_half_width(8'd24);
        random_curves(90, 0, 0);
        random_curves(90, 72, 0);
        drain();

        write_half_width(8'd255);
        random_curves(90, 0, 72);
        drain();

        write_half_width(8'd0);
        random_curves(20, 6, 6);
        drain();

        write_half_width(8'($urandom_range(1, 254)));
        random_curves(60, 6, 6);
        drain();

        if (scoreboard.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
